// ----- rtl/xml_escape_encoder_core_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the XML escape encoder
// Shorthand for clocked implication checks.
// ---------------------------------------------------------------------------
`ifndef XML_ESCAPE_ENCODER_CORE_MACROS_SVH
`define XML_ESCAPE_ENCODER_CORE_MACROS_SVH

// same-cycle implication, off while reset is high
`define XEE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is high
`define XEE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define XEE_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/xee_pkg.sv -----
// ---------------------------------------------------------------------------
// XML escape encoder package
// Shared types, character codes and the entity string tables.
// ---------------------------------------------------------------------------
package xee_pkg;

  localparam int CP_W        = 21;
  localparam int BYTE_W      = 8;
  localparam int NDIG_W      = 3;   // digit count 1..7
  localparam int POS_W       = 4;   // byte index within one word's expansion, 0..9
  localparam int THR_W       = 24;  // wide enough for 9 * 10^6
  localparam int QUEUE_DEPTH = 2;

  // input code points of interest
  localparam logic [CP_W-1:0] CP_LF    = 21'h00000A;
  localparam logic [CP_W-1:0] CP_SPACE = 21'h000020;
  localparam logic [CP_W-1:0] CP_QUOT  = 21'h000022;
  localparam logic [CP_W-1:0] CP_AMP   = 21'h000026;
  localparam logic [CP_W-1:0] CP_APOS  = 21'h000027;
  localparam logic [CP_W-1:0] CP_LT    = 21'h00003C;
  localparam logic [CP_W-1:0] CP_GT    = 21'h00003E;
  localparam logic [CP_W-1:0] CP_DEL   = 21'h00007F;
  localparam logic [CP_W-1:0] CP_NULL  = 21'h000000;

  // output bytes of the numeric reference
  localparam logic [BYTE_W-1:0] CH_AMP  = 8'h26;
  localparam logic [BYTE_W-1:0] CH_HASH = 8'h23;
  localparam logic [BYTE_W-1:0] CH_SEMI = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;

  typedef enum logic [1:0] {
    JOB_PASS,
    JOB_NAMED,
    JOB_DEC
  } job_kind_t;

  typedef enum logic [2:0] {
    STR_AMP,
    STR_LT,
    STR_GT,
    STR_APOS,
    STR_QUOT,
    STR_BR
  } str_id_t;

  // one classified word, as queued between front and back
  typedef struct packed {
    job_kind_t         kind;
    str_id_t           str;
    logic [NDIG_W-1:0] ndig;
    logic [CP_W-1:0]   value;
  } job_t;

  // entity text, left aligned, zero padded to six bytes
  function automatic logic [47:0] str_text(str_id_t id);
    unique case (id)
      STR_AMP:  return {"&amp;", 8'h00};
      STR_LT:   return {"&lt;", 16'h0000};
      STR_GT:   return {"&gt;", 16'h0000};
      STR_APOS: return "&apos;";
      STR_QUOT: return "&quot;";
      STR_BR:   return {"<br>", 16'h0000};
      default:  return 48'h0;
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] str_byte(str_id_t id, logic [2:0] pos);
    logic [47:0] t;
    t = str_text(id) << {pos, 3'b000};
    return t[47:40];
  endfunction

  // index of the final byte of each entity
  function automatic logic [2:0] str_last(str_id_t id);
    unique case (id)
      STR_AMP:  return 3'd4;
      STR_LT:   return 3'd3;
      STR_GT:   return 3'd3;
      STR_APOS: return 3'd5;
      STR_QUOT: return 3'd5;
      STR_BR:   return 3'd3;
      default:  return 3'd0;
    endcase
  endfunction

  function automatic logic [THR_W-1:0] pow10(logic [NDIG_W-1:0] k);
    unique case (k)
      3'd0:    return 24'd1;
      3'd1:    return 24'd10;
      3'd2:    return 24'd100;
      3'd3:    return 24'd1000;
      3'd4:    return 24'd10000;
      3'd5:    return 24'd100000;
      3'd6:    return 24'd1000000;
      default: return 24'd0;
    endcase
  endfunction

endpackage

// ----- rtl/xee_in_if.sv -----
// ---------------------------------------------------------------------------
// Code point channel
// Valid/ready channel carrying one code point per word.
// ---------------------------------------------------------------------------
interface xee_in_if;
  import xee_pkg::*;

  logic            valid;
  logic            ready;
  logic [CP_W-1:0] code_point;

  modport source (output valid, output code_point, input ready);
  modport sink   (input valid, input code_point, output ready);
endinterface

// ----- rtl/xee_out_if.sv -----
// ---------------------------------------------------------------------------
// Escaped byte channel
// Valid/ready channel carrying one output byte and its last flag per word.
// ---------------------------------------------------------------------------
interface xee_out_if;
  import xee_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last_byte;

  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

// ----- rtl/xee_front.sv -----
// ---------------------------------------------------------------------------
// XML escape encoder front end
// Accepts code points and classifies each nonzero one into a queued job.
// ---------------------------------------------------------------------------
module xee_front (
  xee_in_if.sink       chars,
  input  logic         text_mode,
  input  logic         full,
  output logic         push,
  output xee_pkg::job_t job
);
  import xee_pkg::*;

  logic [CP_W-1:0]   cp;
  logic [NDIG_W-1:0] ndig;

  assign cp          = chars.code_point;
  assign chars.ready = !full;
  // end-of-text code point is taken and dropped
  assign push        = chars.valid && !full && (cp != CP_NULL);

  // decimal digit count: one plus the number of powers 10^1..10^6 not above cp
  always_comb begin
    ndig = NDIG_W'(1);
    for (int j = 1; j < 7; j++) begin
      if ({3'b000, cp} >= pow10(NDIG_W'(j))) ndig = ndig + NDIG_W'(1);
    end
  end

  always_comb begin
    job.kind  = JOB_PASS;
    job.str   = STR_AMP;
    job.ndig  = ndig;
    job.value = cp;
    if (cp == CP_AMP) begin
      job.kind = JOB_NAMED;
      job.str  = STR_AMP;
    end else if (cp == CP_LT) begin
      job.kind = JOB_NAMED;
      job.str  = STR_LT;
    end else if (cp == CP_GT) begin
      job.kind = JOB_NAMED;
      job.str  = STR_GT;
    end else if (cp == CP_APOS) begin
      job.kind = JOB_NAMED;
      job.str  = STR_APOS;
    end else if (cp == CP_QUOT) begin
      job.kind = JOB_NAMED;
      job.str  = STR_QUOT;
    end else if (text_mode && cp == CP_LF) begin
      job.kind = JOB_NAMED;
      job.str  = STR_BR;
    end else if (cp >= CP_DEL || cp < CP_SPACE) begin
      job.kind = JOB_DEC;
    end
  end
endmodule

// ----- rtl/xee_queue.sv -----
// ---------------------------------------------------------------------------
// XML escape encoder job queue
// Small register FIFO between the front end and the byte sequencer.
// ---------------------------------------------------------------------------
module xee_queue #(
  parameter int DEPTH = xee_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  xee_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output xee_pkg::job_t head_job
);
  import xee_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (push && !pop)      count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end
endmodule

// ----- rtl/xee_back.sv -----
// ---------------------------------------------------------------------------
// XML escape encoder byte sequencer
// Expands the head job into bytes, one per cycle while the output is not stalled, into the output register.
// ---------------------------------------------------------------------------
module xee_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  xee_pkg::job_t head_job,
  output logic          pop,
  xee_out_if.source     bytes
);
  import xee_pkg::*;

  logic [POS_W-1:0]  pos;
  logic [CP_W-1:0]   rem;        // value left to print
  logic [NDIG_W-1:0] k;          // power of ten of the next digit
  logic              adv;
  logic [BYTE_W-1:0] byte_next;
  logic              last_next;
  logic [POS_W-1:0]  semi_pos;
  logic              is_digit;
  logic [3:0]        digit;
  logic [THR_W-1:0]  sub;
  logic [THR_W-1:0]  thr [9];

  assign adv      = head_valid && (!bytes.valid || bytes.ready);
  assign pop      = adv && last_next;
  assign semi_pos = POS_W'(head_job.ndig) + POS_W'(2);
  assign is_digit = (pos >= POS_W'(2)) && (pos < semi_pos);

  // leading digit by compare against the nine multiples of 10^k
  always_comb begin
    digit = '0;
    sub   = '0;
    for (int m = 1; m < 10; m++) begin
      thr[m-1] = pow10(k) * THR_W'(m);
      if ({3'b000, rem} >= thr[m-1]) begin
        digit = 4'(m);
        sub   = thr[m-1];
      end
    end
  end

  always_comb begin
    byte_next = '0;
    last_next = 1'b1;
    unique case (head_job.kind)
      JOB_PASS: begin
        byte_next = head_job.value[BYTE_W-1:0];
      end
      JOB_NAMED: begin
        byte_next = str_byte(head_job.str, pos[2:0]);
        last_next = (pos[2:0] == str_last(head_job.str));
      end
      JOB_DEC: begin
        last_next = (pos == semi_pos);
        if (pos == POS_W'(0))      byte_next = CH_AMP;
        else if (pos == POS_W'(1)) byte_next = CH_HASH;
        else if (is_digit)         byte_next = CH_ZERO + {4'b0000, digit};
        else                       byte_next = CH_SEMI;
      end
      default: begin
        byte_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes.valid <= 1'b0;
      pos         <= '0;
    end else if (adv) begin
      bytes.valid <= 1'b1;
      pos         <= last_next ? '0 : pos + POS_W'(1);
    end else if (bytes.ready) begin
      bytes.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bytes.out_byte  <= byte_next;
      bytes.last_byte <= last_next;
      if (head_job.kind == JOB_DEC) begin
        if (pos == POS_W'(0)) begin
          rem <= head_job.value;
          k   <= head_job.ndig - NDIG_W'(1);
        end else if (is_digit) begin
          rem <= rem - sub[CP_W-1:0];
          k   <= k - NDIG_W'(1);
        end
      end
    end
  end
endmodule

// ----- rtl/xml_escape_encoder_core.sv -----
// ---------------------------------------------------------------------------
// XML escape encoder core
// Turns a stream of code points into XML-escaped bytes with a last flag.
// ---------------------------------------------------------------------------
//
//  channel       dir  payload                         handshake
//  char_stream   in   code_point[20:0]                valid/ready
//  byte_stream   out  out_byte[7:0], last_byte        valid/ready
//  cfg           in   cfg_wdata (text_mode)           cfg_we, no ready
//
// Flow: printable ASCII passes at one code point per cycle while the output
// is not held. An escaped code point holds the byte sequencer until all of
// its output bytes are out: 4 to 6 for named entities and the line-break
// tag, 4 to 10 for a decimal reference. From accept, a code point passes
// through the job queue and then the output register.
// Reset: rst clears the queue, the output valid flag and text_mode.
// Stalls: the two-entry job queue and the output register let the input
// keep flowing while the output is held; the input stalls only when the
// queue is full.
//
module xml_escape_encoder_core #(
  parameter int QUEUE_DEPTH = xee_pkg::QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  xee_in_if.sink    char_stream,
  xee_out_if.source byte_stream
);
  import xee_pkg::*;

  logic text_mode;   // newline becomes <br> when set

  // front to queue
  logic push;
  job_t push_job;
  logic full;

  // queue to back
  logic pop;
  logic head_valid;
  job_t head_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_mode <= 1'b0;
    end else if (cfg_we) begin
      text_mode <= cfg_wdata;
    end
  end

  // classify each accepted code point; zero is dropped here
  xee_front u_front (
    .chars     (char_stream),
    .text_mode (text_mode),
    .full      (full),
    .push      (push),
    .job       (push_job)
  );

  xee_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // emits one byte per cycle while the output is not stalled, pops the job on its last byte
  xee_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .bytes      (byte_stream)
  );
endmodule

// ----- rtl/xee_checker.sv -----
// ---------------------------------------------------------------------------
// XML escape encoder port checker
// Port-level checks bound to the encoder core.
// ---------------------------------------------------------------------------
`include "xml_escape_encoder_core_macros.svh"

module xee_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       last_byte
);
  import xee_pkg::*;

  `XEE_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(last_byte), "held byte changed while stalled")

  `XEE_ASSERT_NEXT_ALWAYS(a_reset_idle, clk, rst, !out_valid, "byte valid right after reset")

  // bytes of one expansion follow each other without gaps
  `XEE_ASSERT_NEXT(a_no_gap, clk, rst, out_valid && out_ready && !last_byte, out_valid, "gap inside an escape sequence")

  // a semicolon only ever closes a sequence or stands alone
  `XEE_ASSERT_IMPLY(a_semi_last, clk, rst, out_valid && out_byte == CH_SEMI, last_byte, "semicolon not flagged as last")
endmodule

bind xml_escape_encoder_core xee_checker u_xee_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (byte_stream.valid),
  .out_ready (byte_stream.ready),
  .out_byte  (byte_stream.out_byte),
  .last_byte (byte_stream.last_byte)
);

// ----- bench/xee_escape_checker.sv -----
// ---------------------------------------------------------------------------
// XML escape encoder checker
// Watches the code point, byte and config ports, predicts the escaped byte
// stream for every accepted code point and compares each output word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module xee_escape_checker (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_wdata,
  xee_in_if    in_ch,
  xee_out_if   out_ch,
  output int   errors,
  output int   pending
);
  import xee_pkg::*;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              is_last;
  } esc_byte_t;

  esc_byte_t escaped_q[$];
  logic      br_mode;
  int        err_count = 0;

  assign errors = err_count;

  task automatic report_mismatch(input string what);
    $display("%0t ns  checker: %s", $realtime, what);
    err_count++;
  endtask

  // append the escaped bytes of one code point to the expected stream
  function automatic void push_escaped(input logic [CP_W-1:0] cp, input logic br);
    string s;
    if (cp == CP_NULL) return;   // end of text: nothing comes out
    case (cp)
      CP_AMP:  s = "&amp;";
      CP_LT:   s = "&lt;";
      CP_GT:   s = "&gt;";
      CP_APOS: s = "&apos;";
      CP_QUOT: s = "&quot;";
      default: begin
        if (br && cp == CP_LF) begin
          s = "<br>";
        end else if (cp >= CP_SPACE && cp < CP_DEL) begin
          escaped_q.push_back('{data: cp[BYTE_W-1:0], is_last: 1'b1});
          return;
        end else begin
          s = $sformatf("&#%0d;", cp);
        end
      end
    endcase
    for (int i = 0; i < s.len(); i++)
      escaped_q.push_back('{data: s[i], is_last: (i == s.len() - 1)});
  endfunction

  always @(posedge clk) begin
    esc_byte_t exp_b;
    if (rst) begin
      br_mode = 1'b0;
      escaped_q.delete();
    end else begin
      if (cfg_we) br_mode = cfg_wdata;
      if (in_ch.valid && in_ch.ready) push_escaped(in_ch.code_point, br_mode);
      if (out_ch.valid && out_ch.ready) begin
        if (escaped_q.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h last %0b",
                                    out_ch.out_byte, out_ch.last_byte));
        end else begin
          exp_b = escaped_q.pop_front();
          if (out_ch.out_byte !== exp_b.data)
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      out_ch.out_byte, exp_b.data));
          if (out_ch.last_byte !== exp_b.is_last)
            report_mismatch($sformatf("last_byte %0b, expected %0b (byte %02h)",
                                      out_ch.last_byte, exp_b.is_last, exp_b.data));
        end
      end
    end
    pending <= escaped_q.size();
  end

endmodule

// ----- bench/tb.sv -----
// ---------------------------------------------------------------------------
// XML escape encoder testbench
// Drives code points and random back-pressure into the encoder, flips the
// line-break mode between phases, and leaves all checking to the checker.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import xee_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000; // cycles with no word moving on either side
  localparam int SETTLE_CYCLES  = 8;    // longer than the queue and output register path, covers dropped NUL words
  localparam int TAIL_CYCLES    = 20;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;
  logic steady;        // when set, neither side idles
  int   errors;
  int   pending;
  int   idle_cycles;

  xee_in_if  in_ch();
  xee_out_if out_ch();

  xml_escape_encoder_core u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .char_stream (in_ch),
    .byte_stream (out_ch)
  );

  xee_escape_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .errors    (errors),
    .pending   (pending)
  );

  // directed words with line breaks off: printable edges, delete and
  // control codes, end of text, all five entity characters, newline as a
  // numeric reference, decimal lengths 3, 4 and 7 up to the widest 21-bit value,
  // plus a surrogate of length 5
  logic [CP_W-1:0] plain_cases [0:17] = '{
    21'h000041, CP_SPACE, 21'h00007E, CP_DEL, 21'h00001F, 21'h000001,
    CP_NULL, CP_AMP, CP_LT, CP_GT, CP_APOS, CP_QUOT,
    CP_LF, 21'h000080, 21'h0003E8, 21'h10FFFF, 21'h1FFFFF, 21'h00D800
  };

  // directed words with line breaks on: back-to-back newlines, an entity,
  // tab still as a reference, end of text, plain letter
  logic [CP_W-1:0] br_cases [0:5] = '{
    CP_LF, CP_LF, CP_AMP, 21'h000009, CP_NULL, 21'h00007A
  };

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---- random code point mix --------------------------------------------
  // mostly plain text, a good share of entity characters and newlines,
  // control codes, decimal references of every length, and the odd fully
  // random 21-bit value so every input bit toggles
  function automatic logic [CP_W-1:0] pick_code_point();
    int unsigned sel;
    int unsigned ndig;
    sel = $urandom_range(0, 99);
    if (sel < 40) return CP_W'($urandom_range(32, 126));
    if (sel < 55) begin
      case ($urandom_range(0, 5))
        0:       return CP_AMP;
        1:       return CP_LT;
        2:       return CP_GT;
        3:       return CP_APOS;
        4:       return CP_QUOT;
        default: return CP_LF;
      endcase
    end
    if (sel < 66) return CP_W'($urandom_range(0, 31));
    if (sel < 68) return CP_DEL;
    if (sel < 84) begin
      ndig = $urandom_range(3, 7);
      return CP_W'($urandom_range(128, (ndig == 7) ? 2097151 : 10 ** ndig - 1));
    end
    return CP_W'($urandom_range(0, 2097151));
  endfunction

  // ---- code point source ------------------------------------------------
  // optional gap first, then hold the word until ready; valid stays high
  // across back-to-back words
  task automatic send_code_point(input logic [CP_W-1:0] cp);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.code_point <= cp;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_code_point(pick_code_point());
  endtask

  // wait until every expected byte has come out
  task automatic wait_drained();
    do @(posedge clk); while (pending != 0);
  endtask

  // mode change only while the encoder is empty; the extra cycles cover
  // a trailing NUL word, which leaves nothing to wait for
  task automatic set_text_mode(input logic mode);
    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // ---- byte sink: random stall before each word -------------------------
  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // ---- watchdog: no word moving for too long ends the run ---------------
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---- main sequence ----------------------------------------------------
  initial begin
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_wdata        <= 1'b0;
    steady           <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.code_point <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // line breaks off (reset value), written explicitly too
    set_text_mode(1'b0);
    foreach (plain_cases[i]) send_code_point(plain_cases[i]);

    set_text_mode(1'b1);
    foreach (br_cases[i]) send_code_point(br_cases[i]);

    // random phases, both modes, one of them with no idling at all
    send_random(70);
    set_text_mode(1'b0);
    send_random(70);
    set_text_mode(1'b1);
    steady <= 1'b1;
    send_random(50);
    steady <= 1'b0;
    set_text_mode(1'b0);
    send_random(70);

    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/xee_pkg.sv
rtl/xee_in_if.sv
rtl/xee_out_if.sv
rtl/xee_front.sv
rtl/xee_queue.sv
rtl/xee_back.sv
rtl/xml_escape_encoder_core.sv
rtl/xee_checker.sv
bench/xee_escape_checker.sv
bench/tb.sv
